// ===== hdl/fcrs_pkg.sv =====
`timescale 1ns / 1ps

package fcrs_pkg;

  // Display size. Columns and rows beyond these are clipped away.
  localparam int unsigned DISPLAY_WIDTH  = 160;
  localparam int unsigned DISPLAY_HEIGHT = 128;

  // Last valid column and row as signed offsets base values.
  localparam logic signed [9:0] X_LAST = 10'(DISPLAY_WIDTH - 1);
  localparam logic signed [9:0] Y_LAST = 10'(DISPLAY_HEIGHT - 1);

  // The radicand 4*T+1 is below 2^18, so the root search starts at 4^8.
  localparam int unsigned RAD_W          = 18;
  localparam int unsigned SQRT_ITERS     = 9;
  localparam int unsigned SQRT_STAGES    = 3;
  localparam int unsigned ITERS_PER_STEP = SQRT_ITERS / SQRT_STAGES;
  localparam logic [RAD_W-1:0] ONE_INIT  = RAD_W'(1) << (2 * (SQRT_ITERS - 1));

  // Item as it travels down the pipeline; later stages fill more fields.
  typedef struct packed {
    logic [7:0]              cx;
    logic [7:0]              row;
    logic [15:0]             color;
    logic                    drawn;
    logic signed [9:0]       left;
    logic signed [9:0]       right;
    logic [15:0]             r2;
    logic [15:0]             hsy;
    logic                    neg;
    logic [RAD_W-1:0]        op;
    logic [RAD_W-1:0]        res;
    logic [RAD_W-1:0]        one;
  } fcrs_item_t;

  // Finished span.
  typedef struct packed {
    logic        drawn;
    logic [7:0]  start_x;
    logic [7:0]  end_x;
    logic [7:0]  row;
    logic [15:0] color;
  } fcrs_span_t;

endpackage

// ===== hdl/fcrs_prep.sv =====
`timescale 1ns / 1ps

module fcrs_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          center_x_i,
  input  logic [7:0]          center_y_i,
  input  logic [7:0]          circle_radius_i,
  input  logic [7:0]          screen_row_i,
  input  logic [15:0]         fill_color_i,
  output logic                valid_o,
  input  logic                ready_i,
  output fcrs_pkg::fcrs_item_t item_o
);

  logic                 valid_q;
  fcrs_pkg::fcrs_item_t item_d, item_q;

  logic signed [9:0] y;
  logic [7:0]        ay;
  logic [7:0]        min_xr, min_yr;
  logic signed [9:0] x_room, y_room;
  logic signed [9:0] r_s, top, bottom;

  always_comb begin
    r_s    = $signed({2'b00, circle_radius_i});
    y      = $signed({2'b00, screen_row_i}) - $signed({2'b00, center_y_i});
    ay     = y[9] ? 8'(-y) : y[7:0];
    min_xr = (center_x_i < circle_radius_i) ? center_x_i : circle_radius_i;
    min_yr = (center_y_i < circle_radius_i) ? center_y_i : circle_radius_i;
    x_room = fcrs_pkg::X_LAST - $signed({2'b00, center_x_i});
    y_room = fcrs_pkg::Y_LAST - $signed({2'b00, center_y_i});
    top    = -$signed({2'b00, min_yr});
    bottom = (y_room < r_s) ? y_room : r_s;

    item_d       = '0;
    item_d.cx    = center_x_i;
    item_d.row   = screen_row_i;
    item_d.color = fill_color_i;
    item_d.drawn = (y >= top) && (y <= bottom);
    item_d.left  = -$signed({2'b00, min_xr});
    item_d.right = (x_room < r_s) ? x_room : r_s;
    item_d.r2    = circle_radius_i * circle_radius_i;
    item_d.hsy   = 16'(ay * ay) - {8'b0, ay};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/fcrs_radicand.sv =====
`timescale 1ns / 1ps

module fcrs_radicand (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fcrs_pkg::fcrs_item_t item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fcrs_pkg::fcrs_item_t item_o
);

  logic                 valid_q;
  fcrs_pkg::fcrs_item_t item_d, item_q;
  logic signed [16:0]   slack;

  // Columns with x*x-|x| <= slack are inside; that bound becomes
  // (2|x|-1)^2 <= 4*slack+1, which the root search resolves.
  always_comb begin
    slack      = $signed({1'b0, item_i.r2}) - $signed({1'b0, item_i.hsy});
    item_d     = item_i;
    item_d.neg = slack[16];
    item_d.op  = slack[16] ? '0 : {slack[15:0], 2'b01};
    item_d.res = '0;
    item_d.one = fcrs_pkg::ONE_INIT;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/fcrs_sqrt_step.sv =====
`timescale 1ns / 1ps

module fcrs_sqrt_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fcrs_pkg::fcrs_item_t item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fcrs_pkg::fcrs_item_t item_o
);

  logic                         valid_q;
  fcrs_pkg::fcrs_item_t         item_d, item_q;
  logic [fcrs_pkg::RAD_W-1:0]   trial;

  // A few bits of the digit-by-digit integer square root.
  always_comb begin
    item_d = item_i;
    trial  = '0;
    for (int k = 0; k < fcrs_pkg::ITERS_PER_STEP; k++) begin
      trial = item_d.res + item_d.one;
      if (item_d.op >= trial) begin
        item_d.op  = item_d.op - trial;
        item_d.res = (item_d.res >> 1) + item_d.one;
      end else begin
        item_d.res = item_d.res >> 1;
      end
      item_d.one = item_d.one >> 2;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/fcrs_span.sv =====
`timescale 1ns / 1ps

module fcrs_span (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fcrs_pkg::fcrs_item_t item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fcrs_pkg::fcrs_span_t span_o
);

  logic                 valid_q;
  fcrs_pkg::fcrs_span_t span_d, span_q;

  logic [7:0]        half;
  logic signed [9:0] m_pos, m_neg, lo, hi;
  logic              run;
  logic [7:0]        lo_off, hi_off;

  // Inside columns form |x| <= (root+1)/2; clip that run to the column window.
  always_comb begin
    half   = 8'(({1'b0, item_i.res[8:0]} + 10'd1) >> 1);
    m_pos  = $signed({2'b00, half});
    m_neg  = -m_pos;
    lo     = (item_i.left > m_neg) ? item_i.left : m_neg;
    hi     = (item_i.right < m_pos) ? item_i.right : m_pos;
    run    = !item_i.neg && (lo <= hi);
    lo_off = run ? lo[7:0] : 8'd0;
    hi_off = run ? hi[7:0] : 8'd0;

    span_d.drawn   = item_i.drawn;
    span_d.start_x = item_i.drawn ? item_i.cx + lo_off : 8'd0;
    span_d.end_x   = item_i.drawn ? item_i.cx + hi_off : 8'd0;
    span_d.row     = item_i.row;
    span_d.color   = item_i.color;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      span_q <= span_d;
    end
  end

  assign valid_o = valid_q;
  assign span_o  = span_q;

endmodule

// ===== hdl/filled_circle_row_span.sv =====
`timescale 1ns / 1ps

// Filled circle row span. Each input beat names a circle (center, radius,
// color) and one display row; the output beat gives the horizontal span to
// fill on that row, clipped to the display, plus a flag that tells whether
// the row lies within the circle's clipped vertical range. A column at
// offset x is inside when (x*x-|x|) + (y*y-|y|) <= r*r. When no column is
// inside, the span collapses to the single column center_x, and a row that
// is not drawn returns zero span ends. The block is a six-stage pipeline:
// operand setup with the two squares, the radicand, three stages of a
// digit-by-digit square root (three bits each), and the span clip, which is
// also the output register. It takes one beat per clock unless the output
// stalls; a stalled output backs up the pipeline without losing or
// repeating a beat.

module filled_circle_row_span (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  center_x_i,
  input  logic [7:0]  center_y_i,
  input  logic [7:0]  circle_radius_i,
  input  logic [7:0]  screen_row_i,
  input  logic [15:0] fill_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        row_drawn_o,
  output logic [7:0]  span_start_x_o,
  output logic [7:0]  span_end_x_o,
  output logic [7:0]  span_row_o,
  output logic [15:0] span_color_o
);

  // Stage links: index 0 leaves the radicand stage, the last one leaves the
  // final root stage.
  logic                 prep_valid, prep_ready;
  fcrs_pkg::fcrs_item_t prep_item;
  logic                 sq_valid [fcrs_pkg::SQRT_STAGES+1];
  logic                 sq_ready [fcrs_pkg::SQRT_STAGES+1];
  fcrs_pkg::fcrs_item_t sq_item  [fcrs_pkg::SQRT_STAGES+1];
  fcrs_pkg::fcrs_span_t span;

  // Stage one: clip bounds, the row test and both squares.
  fcrs_prep u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .circle_radius_i (circle_radius_i),
    .screen_row_i    (screen_row_i),
    .fill_color_i    (fill_color_i),
    .valid_o         (prep_valid),
    .ready_i         (prep_ready),
    .item_o          (prep_item)
  );

  // Stage two: the budget left for the column term, as a root radicand.
  fcrs_radicand u_radicand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .item_i  (prep_item),
    .valid_o (sq_valid[0]),
    .ready_i (sq_ready[0]),
    .item_o  (sq_item[0])
  );

  // Stages three to five: the square root, a few bits per stage.
  for (genvar s = 0; s < fcrs_pkg::SQRT_STAGES; s++) begin : g_sqrt
    fcrs_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[s]),
      .ready_o (sq_ready[s]),
      .item_i  (sq_item[s]),
      .valid_o (sq_valid[s+1]),
      .ready_i (sq_ready[s+1]),
      .item_o  (sq_item[s+1])
    );
  end

  // Stage six: the inside run is clipped to the column window and offset by
  // the center; this register drives the output ports.
  fcrs_span u_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid[fcrs_pkg::SQRT_STAGES]),
    .ready_o (sq_ready[fcrs_pkg::SQRT_STAGES]),
    .item_i  (sq_item[fcrs_pkg::SQRT_STAGES]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .span_o  (span)
  );

  assign row_drawn_o    = span.drawn;
  assign span_start_x_o = span.start_x;
  assign span_end_x_o   = span.end_x;
  assign span_row_o     = span.row;
  assign span_color_o   = span.color;

  // A row that is not drawn carries zero span ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_drawn_o |-> span_start_x_o == 8'd0 && span_end_x_o == 8'd0)
    else $error("undrawn row with nonzero span");

  // Clipping keeps every span inside one byte without wrap, so it never runs
  // backward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_drawn_o |-> span_start_x_o <= span_end_x_o)
    else $error("span start beyond span end");

  // The pipeline only refuses input when it is full behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule
